// ----- src/dcl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcl_pkg: shared types and constants of the density cluster labeler
// field widths, op and status codes, register indexes, control structs
// ----------------------------------------------------------------------------
package dcl_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int COORD_BITS_DEF = 16;

    localparam int OP_W       = 2;
    localparam int XY_W       = 16;
    localparam int IDX_W      = 10;
    localparam int CNT_W      = 11;
    localparam int LBL_W      = 10;
    localparam int STAT_W     = 2;
    localparam int RAD_W      = 34;
    localparam int MINP_W     = 11;
    localparam int DIM_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 34;

    localparam logic [RAD_W-1:0]  RADIUS_RST = RAD_W'(1);
    localparam logic [MINP_W-1:0] MINP_RST   = MINP_W'(4);
    localparam logic [DIM_W-1:0]  DIM_RST    = DIM_W'(3);
    localparam logic [DIM_W-1:0]  DIM_TWO    = DIM_W'(2);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_RUN   = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_RANGE  = 2'd2,
        ST_NO_RUN = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS = 2'd0,
        CFG_MINP   = 2'd1,
        CFG_DIMS   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic acc_load;
        logic acc_clear;
        logic acc_read;
        logic run_start;
        logic out_read;
        logic out_run;
        logic i_inc;
        logic i_clr;
        logic coord_rd_i;
        logic coord_rd_stk;
        logic a_latch;
        logic sweep_start;
        logic sweep_step;
        logic mode_exp;
        logic core_wr;
        logic seed_rd;
        logic seed_take;
        logic pop;
        logic cluster_inc;
        logic run_end;
    } t_cmd;

    typedef struct packed {
        logic out_valid;
        logic total_zero;
        logic i_last;
        logic j_last;
        logic pipe_busy;
        logic seed_ok;
        logic depth_zero;
    } t_stat;

endpackage

// ----- src/dcl_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcl_req_if: request channel
// op word with point coordinates and read index
// ----------------------------------------------------------------------------
interface dcl_req_if;
    logic                               valid;
    logic                               ready;
    logic [dcl_pkg::OP_W-1:0]           op;
    logic signed [dcl_pkg::XY_W-1:0]    x_coord;
    logic signed [dcl_pkg::XY_W-1:0]    y_coord;
    logic signed [dcl_pkg::XY_W-1:0]    z_coord;
    logic [dcl_pkg::IDX_W-1:0]          point_index;

    modport source (output valid, op, x_coord, y_coord, z_coord, point_index,
                    input ready);
    modport sink (input valid, op, x_coord, y_coord, z_coord, point_index,
                  output ready);
endinterface

// ----- src/dcl_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcl_rsp_if: response channel
// status, counts and the label of a read point
// ----------------------------------------------------------------------------
interface dcl_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [dcl_pkg::STAT_W-1:0]    status;
    logic [dcl_pkg::CNT_W-1:0]     point_count;
    logic [dcl_pkg::LBL_W-1:0]     cluster_label;
    logic                          is_noise;
    logic                          is_core;
    logic [dcl_pkg::CNT_W-1:0]     cluster_total;

    modport source (output valid, status, point_count, cluster_label, is_noise,
                    is_core, cluster_total, input ready);
    modport sink (input valid, status, point_count, cluster_label, is_noise,
                  is_core, cluster_total, output ready);
endinterface

// ----- src/dcl_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcl_ram: simple dual port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module dcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/dcl_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcl_dpath: datapath of the density cluster labeler
// point stores, counters, distance pipe, config and response registers
// ----------------------------------------------------------------------------
module dcl_dpath #(
    parameter int MAX_POINTS = dcl_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = dcl_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [dcl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dcl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  dcl_pkg::t_cmd                   i_cmd,
    input  logic [dcl_pkg::XY_W-1:0]        i_x,
    input  logic [dcl_pkg::XY_W-1:0]        i_y,
    input  logic [dcl_pkg::XY_W-1:0]        i_z,
    input  logic [dcl_pkg::IDX_W-1:0]       i_point_index,
    input  logic                            i_out_ready,
    output dcl_pkg::t_stat                  o_stat,
    output logic [dcl_pkg::STAT_W-1:0]      o_status,
    output logic [dcl_pkg::CNT_W-1:0]       o_point_count,
    output logic [dcl_pkg::LBL_W-1:0]       o_cluster_label,
    output logic                            o_is_noise,
    output logic                            o_is_core,
    output logic [dcl_pkg::CNT_W-1:0]       o_cluster_total
);
    localparam int IW  = $clog2(MAX_POINTS);
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int CB  = COORD_BITS;
    localparam int DW  = CB + 1;
    localparam int PW  = 2 * DW;
    localparam int SW  = PW + 2;
    localparam int MW  = (SW > dcl_pkg::RAD_W) ? SW : dcl_pkg::RAD_W;
    localparam int XW  = 3 * CB;
    localparam int LW  = dcl_pkg::LBL_W + 1;
    localparam int KW  = CW + dcl_pkg::MINP_W;
    localparam int QW  = CW + dcl_pkg::IDX_W;

    // config
    logic [dcl_pkg::RAD_W-1:0]  r_radius;
    logic [dcl_pkg::MINP_W-1:0] r_min;
    logic [dcl_pkg::DIM_W-1:0]  r_dims;

    // run state
    logic [CW-1:0] r_total, r_clusters, r_cnt, r_cluster, r_depth;
    logic          r_run_done;
    logic [IW-1:0] r_i, r_j;
    logic [XW-1:0] r_a;

    // distance pipe
    logic          r_d0_valid, r_s1_valid, r_s1_vis, r_s1_core;
    logic [IW-1:0] r_d0_j, r_s1_j;
    logic [PW-1:0] r_s1_p [3];
    logic [PW-1:0] n_p [3];

    // response
    logic                  r_out_valid;
    dcl_pkg::t_status      r_rd_status;
    logic [dcl_pkg::STAT_W-1:0] r_o_status;
    logic [dcl_pkg::CNT_W-1:0]  r_o_count, r_o_ctotal;
    logic [dcl_pkg::LBL_W-1:0]  r_o_label;
    logic                       r_o_noise, r_o_core;

    // memories
    logic [XW-1:0] coord_rdata;
    logic [LW-1:0] lbl_rdata;
    logic          core_rdata;
    logic [IW-1:0] stk_rdata;

    logic          full, near, cnt_hit, exp_hit, push, core_val, out_any;
    logic [SW-1:0] sum;
    logic          coord_we, coord_re, lbl_we, lbl_re, stk_we;
    logic [IW-1:0] coord_raddr, lbl_waddr, lbl_raddr, stk_waddr, stk_wdata;
    logic [LW-1:0] lbl_wdata;
    logic [XW-1:0] coord_wdata;

    assign full     = (r_total == CW'(MAX_POINTS));
    assign core_val = (KW'(r_cnt) >= KW'(r_min));
    assign out_any  = i_cmd.acc_load | i_cmd.acc_clear | i_cmd.out_read | i_cmd.out_run;

    // per-axis squared differences of latched point and swept point
    always_comb begin
        logic signed [DW-1:0] diff;
        logic [DW-1:0]        mag;
        for (int d = 0; d < 3; d++) begin
            diff = {r_a[d*CB+CB-1], r_a[d*CB +: CB]}
                 - {coord_rdata[d*CB+CB-1], coord_rdata[d*CB +: CB]};
            mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);
            n_p[d] = PW'(mag) * PW'(mag);
        end
    end

    assign sum = SW'(r_s1_p[0]) + SW'(r_s1_p[1])
               + ((r_dims == dcl_pkg::DIM_TWO) ? SW'(0) : SW'(r_s1_p[2]));
    assign near    = (MW'(sum) <= MW'(r_radius));
    assign cnt_hit = r_s1_valid & ~i_cmd.mode_exp & near & (r_s1_j != r_i);
    assign exp_hit = r_s1_valid & i_cmd.mode_exp & near & ~r_s1_vis;
    assign push    = exp_hit & r_s1_core & (r_depth < CW'(MAX_POINTS));

    // memory port steering
    assign coord_we    = i_cmd.acc_load & ~full;
    assign coord_wdata = {CB'(i_z), CB'(i_y), CB'(i_x)};
    assign coord_re    = i_cmd.coord_rd_i | i_cmd.coord_rd_stk | i_cmd.sweep_step;
    assign coord_raddr = i_cmd.sweep_step ? r_j : (i_cmd.coord_rd_stk ? stk_rdata : r_i);

    assign lbl_we    = i_cmd.core_wr | i_cmd.seed_take | exp_hit;
    assign lbl_waddr = exp_hit ? r_s1_j : r_i;
    assign lbl_wdata = i_cmd.core_wr ? {1'b1, dcl_pkg::LBL_W'(0)}
                                     : {1'b0, dcl_pkg::LBL_W'(r_cluster)};
    assign lbl_re    = i_cmd.acc_read | i_cmd.seed_rd | i_cmd.sweep_step;
    assign lbl_raddr = i_cmd.sweep_step ? r_j
                     : (i_cmd.seed_rd ? r_i : IW'(i_point_index));

    assign stk_we    = i_cmd.seed_take | push;
    assign stk_waddr = i_cmd.seed_take ? IW'(0) : IW'(r_depth);
    assign stk_wdata = i_cmd.seed_take ? r_i : r_s1_j;

    dcl_ram #(.WIDTH(XW), .DEPTH(MAX_POINTS)) u_coord_ram (
        .i_clk(i_clk), .i_we(coord_we), .i_waddr(IW'(r_total)), .i_wdata(coord_wdata),
        .i_re(coord_re), .i_raddr(coord_raddr), .o_rdata(coord_rdata)
    );
    dcl_ram #(.WIDTH(LW), .DEPTH(MAX_POINTS)) u_label_ram (
        .i_clk(i_clk), .i_we(lbl_we), .i_waddr(lbl_waddr), .i_wdata(lbl_wdata),
        .i_re(lbl_re), .i_raddr(lbl_raddr), .o_rdata(lbl_rdata)
    );
    dcl_ram #(.WIDTH(1), .DEPTH(MAX_POINTS)) u_core_ram (
        .i_clk(i_clk), .i_we(i_cmd.core_wr), .i_waddr(r_i), .i_wdata(core_val),
        .i_re(lbl_re), .i_raddr(lbl_raddr), .o_rdata(core_rdata)
    );
    dcl_ram #(.WIDTH(IW), .DEPTH(MAX_POINTS)) u_stack_ram (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_re(i_cmd.pop), .i_raddr(IW'(r_depth - CW'(1))), .o_rdata(stk_rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius    <= dcl_pkg::RADIUS_RST;
            r_min       <= dcl_pkg::MINP_RST;
            r_dims      <= dcl_pkg::DIM_RST;
            r_total     <= '0;
            r_clusters  <= '0;
            r_run_done  <= 1'b0;
            r_depth     <= '0;
            r_d0_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    dcl_pkg::CFG_RADIUS: r_radius <= i_cfg_data[dcl_pkg::RAD_W-1:0];
                    dcl_pkg::CFG_MINP:   r_min    <= i_cfg_data[dcl_pkg::MINP_W-1:0];
                    dcl_pkg::CFG_DIMS:   r_dims   <= i_cfg_data[dcl_pkg::DIM_W-1:0];
                    default: ;
                endcase
            end
            if (coord_we) begin
                r_total    <= r_total + CW'(1);
                r_run_done <= 1'b0;
            end
            if (i_cmd.acc_clear) begin
                r_total    <= '0;
                r_clusters <= '0;
                r_run_done <= 1'b0;
            end
            if (i_cmd.run_end) begin
                r_clusters <= r_cluster;
                r_run_done <= 1'b1;
            end
            if (i_cmd.seed_take) begin
                r_depth <= CW'(1);
            end else if (i_cmd.pop) begin
                r_depth <= r_depth - CW'(1);
            end else if (push) begin
                r_depth <= r_depth + CW'(1);
            end
            r_d0_valid <= i_cmd.sweep_step;
            r_s1_valid <= r_d0_valid;
            if (out_any) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // counters, pipe payload and response payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.run_start || i_cmd.i_clr) begin
            r_i <= '0;
        end else if (i_cmd.i_inc) begin
            r_i <= r_i + IW'(1);
        end
        if (i_cmd.run_start) begin
            r_cluster <= '0;
        end else if (i_cmd.cluster_inc) begin
            r_cluster <= r_cluster + CW'(1);
        end
        if (i_cmd.sweep_start) begin
            r_j   <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.sweep_step) begin
                r_j <= r_j + IW'(1);
            end
            if (cnt_hit) begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
        if (i_cmd.a_latch) begin
            r_a <= coord_rdata;
        end
        r_d0_j <= r_j;
        r_s1_j <= r_d0_j;
        for (int d = 0; d < 3; d++) begin
            r_s1_p[d] <= n_p[d];
        end
        r_s1_vis  <= ~lbl_rdata[LW-1];
        r_s1_core <= core_rdata;

        if (i_cmd.acc_read) begin
            if (!r_run_done) begin
                r_rd_status <= dcl_pkg::ST_NO_RUN;
            end else if (QW'(i_point_index) >= QW'(r_total)) begin
                r_rd_status <= dcl_pkg::ST_RANGE;
            end else begin
                r_rd_status <= dcl_pkg::ST_OK;
            end
        end
        if (out_any) begin
            r_o_status <= dcl_pkg::ST_OK;
            r_o_count  <= dcl_pkg::CNT_W'(r_total);
            r_o_label  <= '0;
            r_o_noise  <= 1'b0;
            r_o_core   <= 1'b0;
            r_o_ctotal <= dcl_pkg::CNT_W'(r_clusters);
            if (i_cmd.acc_load) begin
                if (full) begin
                    r_o_status <= dcl_pkg::ST_FULL;
                end else begin
                    r_o_count <= dcl_pkg::CNT_W'(r_total + CW'(1));
                end
            end
            if (i_cmd.acc_clear) begin
                r_o_count  <= '0;
                r_o_ctotal <= '0;
            end
            if (i_cmd.out_run) begin
                r_o_ctotal <= dcl_pkg::CNT_W'(r_cluster);
            end
            if (i_cmd.out_read) begin
                r_o_status <= r_rd_status;
                if (r_rd_status == dcl_pkg::ST_OK) begin
                    r_o_noise <= lbl_rdata[LW-1];
                    r_o_label <= lbl_rdata[LW-1] ? '0 : lbl_rdata[dcl_pkg::LBL_W-1:0];
                    r_o_core  <= core_rdata;
                end
            end
        end
    end

    assign o_stat.out_valid  = r_out_valid;
    assign o_stat.total_zero = (r_total == '0);
    assign o_stat.i_last     = (CW'(r_i) == r_total - CW'(1));
    assign o_stat.j_last     = (CW'(r_j) == r_total - CW'(1));
    assign o_stat.pipe_busy  = r_d0_valid | r_s1_valid;
    assign o_stat.seed_ok    = lbl_rdata[LW-1] & core_rdata;
    assign o_stat.depth_zero = (r_depth == '0);

    assign o_status        = r_o_status;
    assign o_point_count   = r_o_count;
    assign o_cluster_label = r_o_label;
    assign o_is_noise      = r_o_noise;
    assign o_is_core       = r_o_core;
    assign o_cluster_total = r_o_ctotal;

`ifndef NO_ASSERTIONS
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= r_total)
        else $error("walk stack deeper than point count");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_any |-> (!r_out_valid || i_out_ready))
        else $error("response word overwritten before taken");
    a_pipe_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> $past(r_d0_valid))
        else $error("distance stage valid without feeding stage");
`endif
endmodule

// ----- src/dcl_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcl_ctrl: controller of the density cluster labeler
// op dispatch, core count sweeps and cluster expansion sequencing
// ----------------------------------------------------------------------------
module dcl_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [dcl_pkg::OP_W-1:0]   i_in_op,
    input  logic                       i_out_ready,
    input  dcl_pkg::t_stat             i_stat,
    output logic                       o_in_ready,
    output dcl_pkg::t_cmd              o_cmd
);
    typedef enum logic [13:0] {
        S_IDLE      = 14'h0001,
        S_RD_WAIT   = 14'h0002,
        S_CNT_RD    = 14'h0004,
        S_CNT_LAT   = 14'h0008,
        S_CNT_SWEEP = 14'h0010,
        S_CNT_DRAIN = 14'h0020,
        S_SEED_RD   = 14'h0040,
        S_SEED_CHK  = 14'h0080,
        S_POP       = 14'h0100,
        S_POP_WAIT  = 14'h0200,
        S_SRC_LAT   = 14'h0400,
        S_EXP_SWEEP = 14'h0800,
        S_EXP_DRAIN = 14'h1000,
        S_DONE      = 14'h2000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_ready = i_rst_n & (r_state == S_IDLE) & (~i_stat.out_valid | i_out_ready);
    assign accept     = o_in_ready & i_in_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.mode_exp = (r_state == S_EXP_SWEEP) | (r_state == S_EXP_DRAIN);
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (dcl_pkg::t_op'(i_in_op))
                        dcl_pkg::OP_LOAD:  o_cmd.acc_load = 1'b1;
                        dcl_pkg::OP_CLEAR: o_cmd.acc_clear = 1'b1;
                        dcl_pkg::OP_RUN: begin
                            o_cmd.run_start = 1'b1;
                            n_state = i_stat.total_zero ? S_DONE : S_CNT_RD;
                        end
                        dcl_pkg::OP_READ: begin
                            o_cmd.acc_read = 1'b1;
                            n_state = S_RD_WAIT;
                        end
                        default: ;
                    endcase
                end
            end
            S_RD_WAIT: begin
                o_cmd.out_read = 1'b1;
                n_state = S_IDLE;
            end
            S_CNT_RD: begin
                o_cmd.coord_rd_i = 1'b1;
                n_state = S_CNT_LAT;
            end
            S_CNT_LAT: begin
                o_cmd.a_latch = 1'b1;
                o_cmd.sweep_start = 1'b1;
                n_state = S_CNT_SWEEP;
            end
            S_CNT_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_stat.j_last) begin
                    n_state = S_CNT_DRAIN;
                end
            end
            S_CNT_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    o_cmd.core_wr = 1'b1;
                    if (i_stat.i_last) begin
                        o_cmd.i_clr = 1'b1;
                        n_state = S_SEED_RD;
                    end else begin
                        o_cmd.i_inc = 1'b1;
                        n_state = S_CNT_RD;
                    end
                end
            end
            S_SEED_RD: begin
                o_cmd.seed_rd = 1'b1;
                n_state = S_SEED_CHK;
            end
            S_SEED_CHK: begin
                if (i_stat.seed_ok) begin
                    o_cmd.seed_take = 1'b1;
                    n_state = S_POP;
                end else if (i_stat.i_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.i_inc = 1'b1;
                    n_state = S_SEED_RD;
                end
            end
            S_POP: begin
                if (i_stat.depth_zero) begin
                    o_cmd.cluster_inc = 1'b1;
                    if (i_stat.i_last) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.i_inc = 1'b1;
                        n_state = S_SEED_RD;
                    end
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state = S_POP_WAIT;
                end
            end
            S_POP_WAIT: begin
                o_cmd.coord_rd_stk = 1'b1;
                n_state = S_SRC_LAT;
            end
            S_SRC_LAT: begin
                o_cmd.a_latch = 1'b1;
                o_cmd.sweep_start = 1'b1;
                n_state = S_EXP_SWEEP;
            end
            S_EXP_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_stat.j_last) begin
                    n_state = S_EXP_DRAIN;
                end
            end
            S_EXP_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = S_POP;
                end
            end
            S_DONE: begin
                o_cmd.run_end = 1'b1;
                o_cmd.out_run = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef NO_ASSERTIONS
    a_sweep_then_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CNT_SWEEP && i_stat.j_last) |=> (r_state == S_CNT_DRAIN))
        else $error("count sweep did not end in drain");
    a_run_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_run |-> !i_stat.out_valid)
        else $error("run result while a response word is pending");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pop |-> !i_stat.depth_zero)
        else $error("pop from empty walk stack");
`endif
endmodule

// ----- src/density_cluster_labeler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// density_cluster_labeler: dbscan point labeler
// loads points, clears the store, clusters all points and reads labels
// ----------------------------------------------------------------------------
//  channel   dir  handshake       word
//  i_req     in   valid/ready     op, x_coord, y_coord, z_coord, point_index
//  o_rsp     out  valid/ready     status, point_count, cluster_label, is_noise,
//                                 is_core, cluster_total
//  cfg       in   i_cfg_wr_en     i_cfg_index, i_cfg_data (no back-pressure)
//
//  load and clear answer from the idle state, a read first waits on the label ram read
//  a run does a core count sweep for every point, then tests each point as a seed
//  and sweeps once more for every point popped from the walk stack, growing one
//  cluster per seed
//  each sweep streams one point per cycle through the single coord ram read port
//  one word is worked at a time; a new word is taken once the response
//  register is free or being drained in the same cycle
//  synchronous active-low reset clears counts and config; point rams keep data
// ----------------------------------------------------------------------------
module density_cluster_labeler #(
    parameter int MAX_POINTS = dcl_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = dcl_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [dcl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dcl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    dcl_req_if.sink                         i_req,
    dcl_rsp_if.source                       o_rsp
);
    dcl_pkg::t_cmd  cmd;
    dcl_pkg::t_stat stat;

    // sequencer: dispatches ops and steps the count and expansion sweeps
    dcl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_in_op     (i_req.op),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_in_ready  (i_req.ready),
        .o_cmd       (cmd)
    );

    // stores, distance pipe and response register
    dcl_dpath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (cmd),
        .i_x             ($unsigned(i_req.x_coord)),
        .i_y             ($unsigned(i_req.y_coord)),
        .i_z             ($unsigned(i_req.z_coord)),
        .i_point_index   (i_req.point_index),
        .i_out_ready     (o_rsp.ready),
        .o_stat          (stat),
        .o_status        (o_rsp.status),
        .o_point_count   (o_rsp.point_count),
        .o_cluster_label (o_rsp.cluster_label),
        .o_is_noise      (o_rsp.is_noise),
        .o_is_core       (o_rsp.is_core),
        .o_cluster_total (o_rsp.cluster_total)
    );

    assign o_rsp.valid = stat.out_valid;
endmodule
